@@ rtl/lbrd_pkg.sv @@
package lbrd_pkg;

	// Operation codes carried in bits 7..5 of the request byte.
	localparam logic [2:0] OP_ECHO = 3'd0;
	localparam logic [2:0] OP_CMD  = 3'd1;
	localparam logic [2:0] OP_DATA = 3'd2;
	localparam logic [2:0] OP_SET  = 3'd3;
	localparam logic [2:0] OP_GET  = 3'd4;

	// Target codes for set and get.
	localparam logic [1:0] TGT_CONTRAST   = 2'd0;
	localparam logic [1:0] TGT_BRIGHTNESS = 2'd1;
	localparam logic [1:0] TGT_VERSION    = 2'd0;
	localparam logic [1:0] TGT_KEYS       = 2'd1;
	localparam logic [1:0] TGT_CTRL_MAP   = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_CMD   = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_REPLY = 2'd2;

	// Firmware version reported by get.
	localparam logic [7:0] VER_MAJOR = 8'd1;
	localparam logic [7:0] VER_MINOR = 8'd9;

	localparam logic [1:0] REPLY_LEN_FULL = 2'd2;
	localparam logic [1:0] REPLY_LEN_NONE = 2'd0;
	localparam logic [7:0] LEVEL_RESET    = 8'hFF;
	localparam logic [2:0] MAX_WRITES     = 3'd4;

	typedef struct packed {
		logic [7:0] request_code;
		logic [7:0] arg_byte0;
		logic [7:0] arg_byte1;
		logic [7:0] arg_byte2;
		logic [7:0] arg_byte3;
		logic       key_one_level;
		logic       key_two_level;
	} req_t;

	typedef struct packed {
		logic [1:0] item_kind;
		logic [1:0] write_targets;
		logic [7:0] write_byte;
		logic [1:0] reply_length;
		logic [7:0] reply_first;
		logic [7:0] reply_second;
		logic [7:0] contrast_level;
		logic [7:0] brightness_level;
		logic       last_of_run;
	} res_t;

	// Decoded request held by the sequencer for the whole run.
	typedef struct packed {
		logic [2:0]      op;
		logic [1:0]      target;
		logic [1:0]      masked;
		logic [2:0]      writes;
		logic [3:0][7:0] args;
		logic            key_one;
		logic            key_two;
	} job_t;

endpackage

@@ rtl/lbrd_if.sv @@
interface lbrd_req_if;
	import lbrd_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lbrd_res_if;
	import lbrd_pkg::*;

	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/lbrd_result_unit.sv @@
module lbrd_result_unit (
	input  lbrd_pkg::job_t job,
	input  logic [2:0]     step,
	input  logic [1:0]     installed,
	output lbrd_pkg::res_t result
);
	import lbrd_pkg::*;

	// Builds the result for one step of the run: a write while steps remain,
	// the reply after them. The sequencer adds the stored levels.
	always_comb begin
		result = '0;
		if (step < job.writes) begin
			result.item_kind     = (job.op == OP_CMD) ? KIND_CMD : KIND_DATA;
			result.write_targets = job.masked;
			result.write_byte    = job.args[step[1:0]];
		end else begin
			result.item_kind   = KIND_REPLY;
			result.last_of_run = 1'b1;
			case (job.op)
				OP_ECHO: begin
					result.reply_length = REPLY_LEN_FULL;
					result.reply_first  = job.args[0];
					result.reply_second = job.args[1];
				end
				OP_GET: begin
					case (job.target)
						TGT_VERSION: begin
							result.reply_length = REPLY_LEN_FULL;
							result.reply_first  = VER_MAJOR;
							result.reply_second = VER_MINOR;
						end
						TGT_KEYS: begin
							result.reply_length = REPLY_LEN_FULL;
							result.reply_first  = {6'd0, ~job.key_two, ~job.key_one};
						end
						TGT_CTRL_MAP: begin
							result.reply_length = REPLY_LEN_FULL;
							result.reply_first  = {6'd0, installed};
						end
						default: begin
							result.reply_length = REPLY_LEN_NONE;
						end
					endcase
				end
				default: begin
					result.reply_length = REPLY_LEN_NONE;
				end
			endcase
		end
	end
endmodule

@@ rtl/lcd_bridge_request_decoder.sv @@
// Channel  Direction  Contents
// req      sink       request byte, four argument bytes, two key levels
// res      source     LCD command/data writes, then one reply marked last
// cfg      write      installed controller bitmap, write enable and data
//
// A request is taken in IDLE, then one result leaves per cycle from the output
// register while res is not stalled: its writes in order, then the reply.
// The step counter walking the shared result builder sets this order.
// A stall on res holds the output register and the sequencer; req is ready
// again once the reply has been loaded. Reset clears the map and sets both
// levels to full scale.
module lcd_bridge_request_decoder (
	input  logic             clk,
	input  logic             arst_n,
	lbrd_req_if.sink         req,
	lbrd_res_if.source       res,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_wdata
);
	import lbrd_pkg::*;

	typedef enum logic {
		IDLE,
		RUN
	} state_t;

	state_t     state_q;
	job_t       job_q;
	logic [2:0] step_q;
	logic [1:0] installed_q;
	logic [7:0] contrast_q;
	logic [7:0] brightness_q;
	logic       res_valid_q;
	res_t       res_q;
	res_t       built;
	res_t       res_next;
	logic       req_fire;
	logic       load;
	logic [2:0] op;
	logic [1:0] target;
	logic [1:0] masked;

	assign req.ready = (state_q == IDLE);
	assign req_fire  = req.valid && req.ready;
	assign load      = (state_q == RUN) && (!res_valid_q || res.ready);
	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	// Field decode of the incoming request byte.
	assign op     = req.data.request_code[7:5];
	assign target = req.data.request_code[4:3];
	assign masked = target & installed_q;

	lbrd_result_unit u_result (
		.job       (job_q),
		.step      (step_q),
		.installed (installed_q),
		.result    (built)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			installed_q <= '0;
		end else if (cfg_we) begin
			installed_q <= cfg_wdata;
		end
	end

	// Sequencer: capture the request, then step through its results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			step_q       <= '0;
			contrast_q   <= LEVEL_RESET;
			brightness_q <= LEVEL_RESET;
			job_q        <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (req_fire) begin
						job_q.op      <= op;
						job_q.target  <= target;
						job_q.masked  <= masked;
						job_q.writes  <= ((op == OP_CMD || op == OP_DATA) && masked != 2'd0)
							? {1'b0, req.data.request_code[1:0]} + 3'd1 : 3'd0;
						job_q.args    <= {req.data.arg_byte3, req.data.arg_byte2,
							req.data.arg_byte1, req.data.arg_byte0};
						job_q.key_one <= req.data.key_one_level;
						job_q.key_two <= req.data.key_two_level;
						step_q        <= '0;
						state_q       <= RUN;
						// Set takes effect before any result of this request leaves.
						if (op == OP_SET && target == TGT_CONTRAST) begin
							contrast_q <= req.data.arg_byte0;
						end else if (op == OP_SET && target == TGT_BRIGHTNESS) begin
							brightness_q <= req.data.arg_byte0;
						end
					end
				end
				RUN: begin
					if (load) begin
						step_q <= step_q + 3'd1;
						if (built.last_of_run) begin
							state_q <= IDLE;
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Built result with the stored levels filled in.
	always_comb begin
		res_next                  = built;
		res_next.contrast_level   = contrast_q;
		res_next.brightness_level = brightness_q;
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_next;
		end
	end

`ifndef NO_ASSERTIONS
	// The step counter never runs past the reply step.
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == RUN) |-> (step_q <= job_q.writes))
		else $error("step counter beyond reply step");

	// No run asks for more than four writes.
	a_writes_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == RUN) |-> (job_q.writes <= MAX_WRITES))
		else $error("write count out of range");

	// A loaded reply closes the run and frees the request side.
	a_reply_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(load && built.item_kind == KIND_REPLY) |=> (state_q == IDLE))
		else $error("run did not end after reply");
`endif
endmodule

@@ bench/tb_lcd_bridge_request_decoder.sv @@
module tb_lcd_bridge_request_decoder;
	import lbrd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Spare codes: operations the package leaves unnamed, targets that set does not use.
	localparam logic [2:0] OP_SPARE_A  = 3'd5;
	localparam logic [2:0] OP_SPARE_B  = 3'd6;
	localparam logic [2:0] OP_SPARE_C  = 3'd7;
	localparam logic [1:0] TGT_SPARE_2 = 2'd2;
	localparam logic [1:0] TGT_SPARE_3 = 2'd3;

	// Receiver stall patterns.
	localparam int RX_ALWAYS   = 0;
	localparam int RX_RANDOM   = 1;
	localparam int RX_PERIODIC = 2;
	localparam int RX_LONG     = 3;

	localparam int CYCLE_LIMIT = 100000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_wdata;

	lbrd_req_if req_if ();
	lbrd_res_if res_if ();

	lcd_bridge_request_decoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the block's register and stored levels.
	logic [1:0] controller_map;
	logic [7:0] contrast_shadow;
	logic [7:0] brightness_shadow;

	res_t expected_results[$];
	int mismatches;
	int cycle_count;
	int rx_mode;
	int rx_phase;

	// Free-running clock, 20 ns period.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog on the total run length.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver back-pressure, following the pattern currently selected.
	always @(posedge clk) begin
		rx_phase <= rx_phase + 1;
		case (rx_mode)
			RX_ALWAYS:   res_if.ready <= 1'b1;
			RX_RANDOM:   res_if.ready <= ($urandom_range(9) >= 3);
			RX_PERIODIC: res_if.ready <= ((rx_phase % 7) >= 3);
			default:     res_if.ready <= ((rx_phase % 12) < 3);
		endcase
	end

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Compare every result transaction against the oldest expectation.
	always @(posedge clk) begin : result_check
		res_t want;
		res_t got;
		if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			got = res_if.data;
			if (expected_results.size() == 0) begin
				$error("result transaction with nothing expected: %h", got);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("item_kind", 8'(want.item_kind), 8'(got.item_kind));
				check_field("write_targets", 8'(want.write_targets),
					8'(got.write_targets));
				check_field("write_byte", want.write_byte, got.write_byte);
				check_field("reply_length", 8'(want.reply_length), 8'(got.reply_length));
				check_field("reply_first", want.reply_first, got.reply_first);
				check_field("reply_second", want.reply_second, got.reply_second);
				check_field("contrast_level", want.contrast_level, got.contrast_level);
				check_field("brightness_level", want.brightness_level,
					got.brightness_level);
				check_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
			end
		end
	end

	// Work out the writes and the reply that one request produces.
	task automatic decode_request(input req_t r);
		logic [2:0] op;
		logic [1:0] tgt;
		logic [1:0] masked;
		logic [7:0] args[4];
		int writes;
		res_t item;
		op = r.request_code[7:5];
		tgt = r.request_code[4:3];
		masked = 2'd0;
		writes = 0;
		args[0] = r.arg_byte0;
		args[1] = r.arg_byte1;
		args[2] = r.arg_byte2;
		args[3] = r.arg_byte3;
		item = '0;
		item.item_kind = KIND_REPLY;
		item.last_of_run = 1'b1;
		item.reply_length = REPLY_LEN_NONE;
		case (op)
			OP_ECHO: begin
				item.reply_length = REPLY_LEN_FULL;
				item.reply_first = args[0];
				item.reply_second = args[1];
			end
			OP_CMD, OP_DATA: begin
				masked = tgt & controller_map;
				if (masked != 2'd0)
					writes = r.request_code[1:0] + 1;
			end
			OP_SET: begin
				if (tgt == TGT_CONTRAST)
					contrast_shadow = args[0];
				else if (tgt == TGT_BRIGHTNESS)
					brightness_shadow = args[0];
			end
			OP_GET: begin
				if (tgt == TGT_VERSION) begin
					item.reply_length = REPLY_LEN_FULL;
					item.reply_first = VER_MAJOR;
					item.reply_second = VER_MINOR;
				end else if (tgt == TGT_KEYS) begin
					// Key pins are active low: a pressed key reads as a set bit.
					item.reply_length = REPLY_LEN_FULL;
					item.reply_first = {6'd0, ~r.key_two_level, ~r.key_one_level};
				end else if (tgt == TGT_CTRL_MAP) begin
					item.reply_length = REPLY_LEN_FULL;
					item.reply_first = {6'd0, controller_map};
				end
			end
			default: ;
		endcase
		item.contrast_level = contrast_shadow;
		item.brightness_level = brightness_shadow;
		for (int i = 0; i < writes; i++) begin
			res_t wr;
			wr = '0;
			wr.item_kind = (op == OP_CMD) ? KIND_CMD : KIND_DATA;
			wr.write_targets = masked;
			wr.write_byte = args[i];
			wr.contrast_level = contrast_shadow;
			wr.brightness_level = brightness_shadow;
			expected_results.push_back(wr);
		end
		expected_results.push_back(item);
	endtask

	function automatic req_t make_request(input logic [2:0] op, input logic [1:0] tgt,
			input logic [1:0] len_m1, input logic rsv, input logic [31:0] args,
			input logic [1:0] keys);
		req_t r;
		r.request_code = {op, tgt, rsv, len_m1};
		{r.arg_byte0, r.arg_byte1, r.arg_byte2, r.arg_byte3} = args;
		{r.key_one_level, r.key_two_level} = keys;
		return r;
	endfunction

	// Present one request and hold it until the block takes it.
	task automatic send_request(input req_t r);
		req_if.valid <= 1'b1;
		req_if.data <= r;
		do
			@(posedge clk);
		while (req_if.ready !== 1'b1);
		decode_request(r);
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			req_if.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stop sending and let every expected result come out.
	task automatic wait_for_replies();
		if (req_if.valid === 1'b1)
			req_if.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_controller_map(input logic [1:0] m);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		controller_map = m;
		cfg_we <= 1'b0;
	endtask

	// Default state right after reset: empty map, full-scale levels.
	task automatic test_reset_state();
		rx_mode = RX_ALWAYS;
		send_request(make_request(OP_GET, TGT_VERSION, 2'd0, 1'b0, 32'h0, 2'b11));
		send_request(make_request(OP_CMD, 2'd3, 2'd3, 1'b0, 32'h11223344, 2'b11));
		send_request(make_request(OP_GET, TGT_CTRL_MAP, 2'd0, 1'b0, 32'h0, 2'b11));
	endtask

	// Echo, key gets in all combinations, a spare get target and the spare operations.
	task automatic test_echo_and_gets();
		rx_mode = RX_PERIODIC;
		send_request(make_request(OP_ECHO, 2'd0, 2'd0, 1'b0, 32'h00000000, 2'b00));
		send_request(make_request(OP_ECHO, 2'd3, 2'd3, 1'b1, 32'hFFFFFFFF, 2'b11));
		for (int k = 0; k < 4; k++)
			send_request(make_request(OP_GET, TGT_KEYS, 2'd0, 1'b0, 32'h0, k[1:0]));
		send_request(make_request(OP_GET, TGT_SPARE_3, 2'd2, 1'b1, 32'hA5A5A5A5, 2'b01));
		send_request(make_request(OP_SPARE_A, 2'd1, 2'd3, 1'b0, 32'hDEADBEEF, 2'b10));
		send_request(make_request(OP_SPARE_B, 2'd2, 2'd1, 1'b1, 32'h01020304, 2'b00));
		send_request(make_request(OP_SPARE_C, 2'd3, 2'd2, 1'b0, 32'hFFFF0000, 2'b11));
	endtask

	// Contrast and brightness updates, including the targets that store nothing.
	task automatic test_level_settings();
		rx_mode = RX_RANDOM;
		send_request(make_request(OP_SET, TGT_CONTRAST, 2'd0, 1'b0, 32'h00FFFFFF, 2'b11));
		send_request(make_request(OP_SET, TGT_BRIGHTNESS, 2'd3, 1'b1, 32'h00000000, 2'b11));
		send_request(make_request(OP_SET, TGT_SPARE_2, 2'd0, 1'b0, 32'h7E000000, 2'b11));
		send_request(make_request(OP_SET, TGT_SPARE_3, 2'd0, 1'b0, 32'h81000000, 2'b11));
		send_request(make_request(OP_SET, TGT_CONTRAST, 2'd0, 1'b0, 32'hFF000000, 2'b11));
		send_request(make_request(OP_SET, TGT_BRIGHTNESS, 2'd0, 1'b0, 32'h5A000000, 2'b11));
	endtask

	// LCD writes of every length under full and partial controller maps.
	task automatic test_lcd_writes();
		wait_for_replies();
		write_controller_map(2'd3);
		rx_mode = RX_LONG;
		send_request(make_request(OP_CMD, 2'd3, 2'd3, 1'b0, 32'h00FFA55A, 2'b11));
		send_request(make_request(OP_DATA, 2'd1, 2'd0, 1'b1, 32'hC3000000, 2'b11));
		send_request(make_request(OP_DATA, 2'd2, 2'd2, 1'b0, 32'h12345678, 2'b11));
		send_request(make_request(OP_CMD, 2'd0, 2'd3, 1'b0, 32'h99999999, 2'b11));
		wait_for_replies();
		write_controller_map(2'd1);
		send_request(make_request(OP_DATA, 2'd2, 2'd3, 1'b0, 32'hAAAAAAAA, 2'b11));
		send_request(make_request(OP_CMD, 2'd3, 2'd1, 1'b1, 32'h80010000, 2'b11));
	endtask

	function automatic req_t random_request();
		int pick;
		logic [2:0] op;
		req_t r;
		pick = $urandom_range(99);
		if (pick < 15)
			op = OP_ECHO;
		else if (pick < 45)
			op = $urandom_range(1) ? OP_CMD : OP_DATA;
		else if (pick < 60)
			op = OP_SET;
		else if (pick < 80)
			op = OP_GET;
		else
			op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
		r = make_request(op, 2'($urandom_range(3)), 2'($urandom_range(3)),
			1'($urandom_range(1)), $urandom, 2'($urandom_range(3)));
		// Now and then a completely arbitrary request byte.
		if (pick >= 92)
			r.request_code = 8'($urandom_range(255));
		return r;
	endfunction

	// Random traffic in phases, each with its own map, stall pattern and gaps.
	task automatic test_random_traffic();
		logic [1:0] phase_maps[5];
		int burst_left;
		int max_gap;
		phase_maps = '{2'd3, 2'd2, 2'd0, 2'd1, 2'd3};
		for (int phase = 0; phase < 5; phase++) begin
			wait_for_replies();
			write_controller_map(phase == 4 ? 2'($urandom_range(3)) : phase_maps[phase]);
			rx_mode = (phase == 4) ? $urandom_range(RX_ALWAYS, RX_LONG) : phase;
			max_gap = (phase == 0) ? 0 : 6;
			burst_left = $urandom_range(1, 8);
			for (int n = 0; n < 17; n++) begin
				send_request(random_request());
				// Hold off mid-phase until the block has emptied completely.
				if (phase == 1 && n == 11)
					wait_for_replies();
				burst_left--;
				if (burst_left == 0) begin
					idle_cycles($urandom_range(max_gap));
					burst_left = $urandom_range(1, 8);
				end
			end
		end
	endtask

	// Reset, run each test in turn, then drain and report.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 2'd0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		res_if.ready = 1'b0;
		rx_mode = RX_ALWAYS;
		rx_phase = 0;
		mismatches = 0;
		controller_map = 2'd0;
		contrast_shadow = LEVEL_RESET;
		brightness_shadow = LEVEL_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_echo_and_gets();
		test_level_settings();
		test_lcd_writes();
		test_random_traffic();
		wait_for_replies();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
